FILE: rtl/core/sqcl_pkg.sv
// Shared types and character codes for the script quote and comment lexer.
package sqcl_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;

    localparam logic [2:0] Q_NONE = 3'd0;
    localparam logic [2:0] Q_DQ   = 3'd1;
    localparam logic [2:0] Q_SQ   = 3'd2;
    localparam logic [2:0] Q_TDQ  = 3'd3;
    localparam logic [2:0] Q_TSQ  = 3'd4;

    localparam logic [1:0] LE_NONE    = 2'd0;
    localparam logic [1:0] LE_LOGICAL = 2'd1;
    localparam logic [1:0] LE_NEWLINE = 2'd2;
    localparam logic [1:0] LE_CONT    = 2'd3;

    // At most one command per request: up to three bytes to classify,
    // then an optional empty-line result. Without flush only the first
    // byte is classified and the other two are its lookahead.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n;
        logic       flush;
        logic       empty;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/core/script_quote_comment_lexer.sv
// Top level of the script quote and comment lexer: front end, queue, classifier.
// A request's command is written into the queue and its first result is
// registered at the output; a mid-line byte waits for two more bytes of its
// line (lookahead). Throughput: 1 request per cycle while o_stall is low; the
// classifier emits 1 result per cycle unless i_stall holds it (queue absorbs).
// Reset (i_rst_n low, synchronous): clears window, queue, quote state and o_valid.
module script_quote_comment_lexer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last_in_line,
    input  logic       i_empty_line,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_ch,
    output logic       o_dropped,
    output logic       o_inside_string,
    output logic       o_no_char,
    output logic [1:0] o_line_end_kind,
    output logic       o_last_result
);
    import sqcl_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;
    t_cmd       cmd_head;
    t_q_status  q_status;

    // Stall the request side only when the command queue is full.
    assign o_stall = q_status.full;
    assign accept  = i_valid && !o_stall;

    // Front end: hold up to two bytes of lookahead, emit one command per
    // request that produces results.
    sqcl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_ch           (i_ch),
        .i_last_in_line (i_last_in_line),
        .i_empty_line   (i_empty_line),
        .o_push         (push),
        .o_cmd          (cmd_in)
    );

    // Decouple the two sides so each can stall on its own.
    sqcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd_in),
        .i_pop    (pop),
        .o_head   (cmd_head),
        .o_status (q_status)
    );

    // Back end: walk the head command one result at a time, track quote
    // and comment state, drive the registered output.
    sqcl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_head),
        .i_cmd_valid     (!q_status.empty),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_ch        (o_out_ch),
        .o_dropped       (o_dropped),
        .o_inside_string (o_inside_string),
        .o_no_char       (o_no_char),
        .o_line_end_kind (o_line_end_kind),
        .o_last_result   (o_last_result)
    );

    // Queue cannot be full and empty at once.
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    // An accepted empty-line request always leaves a command queued.
    a_empty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_empty_line) |=> !q_status.empty)
        else $error("empty-line request produced no command");

    // A new result only comes from a queued command.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!q_status.empty))
        else $error("result without queued command");

    // An empty-line result never carries a byte or a drop mark.
    a_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_char) |-> (o_out_ch == 8'd0 && !o_dropped
                                    && o_line_end_kind != LE_NONE))
        else $error("malformed empty-line result");

endmodule

FILE: rtl/core/sqcl_front.sv
// Front end: keeps the two-byte lookahead window and builds commands.
module sqcl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_ch,
    input  logic              i_last_in_line,
    input  logic              i_empty_line,
    output logic              o_push,
    output sqcl_pkg::t_cmd    o_cmd
);
    import sqcl_pkg::*;

    logic [7:0] r_win0, r_win1, n_win0, n_win1;
    logic [1:0] r_wc, n_wc;

    always_comb begin
        n_win0 = r_win0;
        n_win1 = r_win1;
        n_wc   = r_wc;
        o_push = 1'b0;
        o_cmd  = '{b0: r_win0, b1: r_win1, b2: i_ch, n: 2'd1, flush: 1'b0, empty: 1'b0};
        if (i_empty_line) begin
            // flush pending bytes, then the empty-line result
            o_push    = 1'b1;
            o_cmd.b2  = 8'd0;
            o_cmd.n   = r_wc;
            o_cmd.flush = 1'b1;
            o_cmd.empty = 1'b1;
            n_wc      = 2'd0;
        end else if (i_last_in_line) begin
            o_push      = 1'b1;
            o_cmd.flush = 1'b1;
            o_cmd.n     = r_wc + 2'd1;
            case (r_wc)
                2'd0: o_cmd.b0 = i_ch;
                2'd1: o_cmd.b1 = i_ch;
                default: o_cmd.b2 = i_ch;
            endcase
            n_wc = 2'd0;
        end else if (r_wc == 2'd2) begin
            // window full: classify the oldest byte, slide the window
            o_push = 1'b1;
            n_win0 = r_win1;
            n_win1 = i_ch;
        end else begin
            if (r_wc == 2'd0) begin
                n_win0 = i_ch;
            end else begin
                n_win1 = i_ch;
            end
            n_wc = r_wc + 2'd1;
        end
        if (!i_accept) begin
            o_push = 1'b0;
            n_win0 = r_win0;
            n_win1 = r_win1;
            n_wc   = r_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= 2'd0;
        end else begin
            r_wc <= n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win0 <= n_win0;
        r_win1 <= n_win1;
    end

endmodule

FILE: rtl/core/sqcl_queue.sv
// Command queue between the front end and the classifier.
module sqcl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sqcl_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output sqcl_pkg::t_cmd       o_head,
    output sqcl_pkg::t_q_status  o_status
);
    import sqcl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            push_ok, pop_ok;

    assign o_status = '{full: (r_count == CW'(DEPTH)), empty: (r_count == '0)};
    assign push_ok = i_push && !o_status.full;
    assign pop_ok  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/sqcl_back.sv
// Back end: quote/comment state, one result/cycle unless stalled.
module sqcl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sqcl_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_out_ch,
    output logic              o_dropped,
    output logic              o_inside_string,
    output logic              o_no_char,
    output logic [1:0]        o_line_end_kind,
    output logic              o_last_result
);
    import sqcl_pkg::*;

    logic [2:0] r_quote, n_quote;
    logic [1:0] r_skip, n_skip;
    logic       r_par, n_par;
    logic       r_comment, n_comment;
    logic [1:0] r_idx;

    logic       advance, is_byte, byte_last, last_res, triple, sopen, lopen, dbl;
    logic       drop, ins, cont;
    logic [7:0] c;
    logic [2:0] total;
    logic [1:0] kind;

    assign sopen = (r_quote == Q_DQ) || (r_quote == Q_SQ);
    assign lopen = (r_quote == Q_TDQ) || (r_quote == Q_TSQ);
    assign total = {1'b0, i_cmd.n} + {2'b00, i_cmd.empty};
    assign is_byte   = r_idx < i_cmd.n;
    assign byte_last = is_byte && i_cmd.flush && ((r_idx + 2'd1) == i_cmd.n);
    assign last_res  = (({1'b0, r_idx}) + 3'd1) == total;
    assign advance   = i_cmd_valid && (!o_valid || !i_stall);
    assign o_pop     = advance && last_res;
    assign dbl       = (c == CH_DQUOTE);
    assign triple    = (r_idx == 2'd0) && (!i_cmd.flush || i_cmd.n == 2'd3)
                       && (i_cmd.b1 == c) && (i_cmd.b2 == c);

    always_comb begin
        case (r_idx)
            2'd0:    c = i_cmd.b0;
            2'd1:    c = i_cmd.b1;
            2'd2:    c = i_cmd.b2;
            default: c = i_cmd.b0;
        endcase
    end

    always_comb begin
        n_quote   = r_quote;
        n_skip    = r_skip;
        n_comment = r_comment;
        n_par     = (c == CH_BACKSLASH) ? ~r_par : 1'b0;
        drop = 1'b0;
        ins  = 1'b0;
        cont = 1'b0;
        if (r_comment) begin
            drop = 1'b1;
        end else if (r_skip != 2'd0) begin
            n_skip = r_skip - 2'd1;
            ins    = 1'b1;
        end else if (c == CH_BACKSLASH) begin
            if (byte_last && !sopen && !lopen) begin
                drop = 1'b1;
                cont = 1'b1;
            end else begin
                ins = sopen || lopen;
            end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            if (r_par) begin
                ins = sopen || lopen;
            end else begin
                ins = 1'b1;
                if (sopen) begin
                    if ((r_quote == Q_DQ) == dbl) begin
                        n_quote = Q_NONE;
                    end
                end else if (lopen) begin
                    if (triple) begin
                        if ((r_quote == Q_TDQ) == dbl) begin
                            n_quote = Q_NONE;
                        end
                        n_skip = 2'd2;
                    end
                end else if (triple) begin
                    n_quote = dbl ? Q_TDQ : Q_TSQ;
                    n_skip  = 2'd2;
                end else begin
                    n_quote = dbl ? Q_DQ : Q_SQ;
                end
            end
        end else if (c == CH_HASH) begin
            if (!sopen && !lopen) begin
                n_comment = 1'b1;
                drop      = 1'b1;
            end else begin
                ins = 1'b1;
            end
        end else begin
            ins = sopen || lopen;
        end

        kind = LE_NONE;
        if (byte_last) begin
            if (n_comment) begin
                kind = LE_LOGICAL;
            end else if (cont) begin
                kind = LE_CONT;
            end else if (n_quote != Q_NONE) begin
                kind = LE_NEWLINE;
            end else begin
                kind = LE_LOGICAL;
            end
            n_skip    = 2'd0;
            n_par     = 1'b0;
            n_comment = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote   <= Q_NONE;
            r_skip    <= 2'd0;
            r_par     <= 1'b0;
            r_comment <= 1'b0;
            r_idx     <= 2'd0;
            o_valid   <= 1'b0;
        end else begin
            if (advance) begin
                o_valid <= 1'b1;
                r_idx   <= last_res ? 2'd0 : r_idx + 2'd1;
                if (is_byte) begin
                    r_quote   <= n_quote;
                    r_skip    <= n_skip;
                    r_par     <= n_par;
                    r_comment <= n_comment;
                end
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_last_result <= last_res;
            if (is_byte) begin
                o_out_ch        <= c;
                o_dropped       <= drop;
                o_inside_string <= ins;
                o_no_char       <= 1'b0;
                o_line_end_kind <= kind;
            end else begin
                o_out_ch        <= 8'd0;
                o_dropped       <= 1'b0;
                o_inside_string <= 1'b0;
                o_no_char       <= 1'b1;
                o_line_end_kind <= (r_quote != Q_NONE) ? LE_NEWLINE : LE_LOGICAL;
            end
        end
    end

endmodule
